[src/awt_pkg.sv]
// Shared types and constants for the address window translator.
// Holds operation, status and register index codes, the window entry type and
// the command and status bundles between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package awt_pkg;

  // Default number of windows in the table.
  localparam int unsigned WindowsDefault = 8;

  // Fixed field widths.
  localparam int unsigned AddrW    = 64;
  localparam int unsigned OpW      = 3;
  localparam int unsigned SlotW    = 3;
  localparam int unsigned CountW   = 4;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 4;

  // Operation codes carried by the input beat.
  typedef enum logic [OpW-1:0] {
    OP_WRITE      = 3'd0,
    OP_DEV2HOST   = 3'd1,
    OP_VIRT2DEV   = 3'd2,
    OP_PHYS2DEV   = 3'd3,
    OP_VALID_TEST = 3'd4
  } op_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_LINK  = 2'd1,
    STATUS_TABLE = 2'd2,
    STATUS_MISS  = 2'd3
  } status_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WINDOW_COUNT = 2'd0,
    CFG_TABLE_READY  = 2'd1,
    CFG_LINK_READY   = 2'd2
  } cfg_idx_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } ctrl_state_e;

  // One window of the table.
  typedef struct packed {
    logic [AddrW-1:0] dev_start;
    logic [AddrW-1:0] dev_end;
    logic [AddrW-1:0] phys_base;
    logic [AddrW-1:0] virt_base;
    logic [AddrW-1:0] length;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic init;
    logic wr_en;
    logic rd_en;
    logic out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_write;
    logic scan_req;
    logic pipe_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

[src/address_window_translator_top.sv]
// Top level of the address window translator.
// Joins the controller (awt_ctrl) and the datapath (awt_dpath); uses awt_pkg.
//
//  Channel  Handshake                  Direction  Payload
//  in       in_valid_i / in_stall_o    to block   operation, window slot, entry, query
//  out      out_valid_o / out_stall_i  from block status, out_virt, out_phys, out_dev, valid
//  cfg      cfg_we_i                   to block   cfg_idx_i, cfg_data_i
//
// A query scans N = min(window_count, WINDOWS) windows, one per cycle through the
// table's single read port, then drains the compare pipeline before its result is
// presented and the next beat can be accepted.
// Writes, rejected queries, unknown operations and scans of zero windows skip
// the scan and go from the decision step straight to the result state. One beat is worked
// on at a time; a finished beat waits in the output register while the next input beat
// is accepted, and a stalled result holds the next one in the result state, which keeps
// the input stalled. Reset clears the configuration and marks every window unused at
// once through per-window use bits.
`timescale 1ns / 1ps
`default_nettype none

module address_window_translator_top #(
  parameter int unsigned WINDOWS = awt_pkg::WindowsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [awt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [awt_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [awt_pkg::OpW-1:0]       operation_i,
  input  wire logic [awt_pkg::SlotW-1:0]     window_index_i,
  input  wire logic [awt_pkg::AddrW-1:0]     entry_dev_start_i,
  input  wire logic [awt_pkg::AddrW-1:0]     entry_dev_end_i,
  input  wire logic [awt_pkg::AddrW-1:0]     entry_phys_base_i,
  input  wire logic [awt_pkg::AddrW-1:0]     entry_virt_base_i,
  input  wire logic [awt_pkg::AddrW-1:0]     entry_length_i,
  input  wire logic [awt_pkg::AddrW-1:0]     query_addr_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [awt_pkg::StatusW-1:0]        status_o,
  output logic [awt_pkg::AddrW-1:0]          out_virt_o,
  output logic [awt_pkg::AddrW-1:0]          out_phys_o,
  output logic [awt_pkg::AddrW-1:0]          out_dev_o,
  output logic                               addr_valid_o
);
  import awt_pkg::*;

  localparam int unsigned CW = $clog2(WINDOWS + 1);
  localparam int unsigned AW = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;

  ctrl_cmd_t     cmd;
  dp_stat_t      stat;
  logic [CW-1:0] scan_limit;
  logic [AW-1:0] rd_idx;

  // Controller.
  awt_ctrl #(
    .WINDOWS (WINDOWS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .stat_i       (stat),
    .scan_limit_i (scan_limit),
    .cmd_o        (cmd),
    .rd_idx_o     (rd_idx)
  );

  // Datapath.
  awt_dpath #(
    .WINDOWS (WINDOWS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .operation_i       (operation_i),
    .window_index_i    (window_index_i),
    .entry_dev_start_i (entry_dev_start_i),
    .entry_dev_end_i   (entry_dev_end_i),
    .entry_phys_base_i (entry_phys_base_i),
    .entry_virt_base_i (entry_virt_base_i),
    .entry_length_i    (entry_length_i),
    .query_addr_i      (query_addr_i),
    .cmd_i             (cmd),
    .rd_idx_i          (rd_idx),
    .stat_o            (stat),
    .scan_limit_o      (scan_limit),
    .status_o          (status_o),
    .out_virt_o        (out_virt_o),
    .out_phys_o        (out_phys_o),
    .out_dev_o         (out_dev_o),
    .addr_valid_o      (addr_valid_o)
  );

endmodule

`default_nettype wire

[src/awt_ctrl.sv]
// Controller state machine of the address window translator.
// Sequences capture, decision, table scan, drain and result hand-off.
// Depends on awt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module awt_ctrl #(
  parameter int unsigned WINDOWS = awt_pkg::WindowsDefault,
  localparam int unsigned CW = $clog2(WINDOWS + 1),
  localparam int unsigned AW = (WINDOWS > 1) ? $clog2(WINDOWS) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  input  wire awt_pkg::dp_stat_t    stat_i,
  input  wire logic [CW-1:0]        scan_limit_i,
  output awt_pkg::ctrl_cmd_t        cmd_o,
  output logic [AW-1:0]             rd_idx_o
);
  import awt_pkg::*;

  ctrl_state_e   state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  logic          out_free;

  // The output register can take a new beat when empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat_i.scan_req && (scan_limit_i != '0)) state_d = S_SCAN;
        else state_d = S_DONE;
      end
      S_SCAN: begin
        if (cnt_q == (scan_limit_i - CW'(1))) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (!stat_i.pipe_busy) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output and command logic.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    cnt_d      = cnt_q;
    case (state_q)
      S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      S_DECIDE: begin
        cmd_o.init  = 1'b1;
        cmd_o.wr_en = stat_i.is_write;
        cnt_d       = '0;
      end
      S_SCAN: begin
        cmd_o.rd_en = 1'b1;
        cnt_d       = cnt_q + CW'(1);
      end
      S_DRAIN: begin
        cmd_o = '0;
      end
      S_DONE: begin
        cmd_o.out_load = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  assign rd_idx_o = cnt_q[AW-1:0];

  // The output beat is held until the consumer takes it.
  assign out_valid_d = cmd_o.out_load ? 1'b1 : (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTH
  // The scan index never runs past the configured window limit.
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (cnt_q < scan_limit_i))
    else $error("scan index beyond window limit");

  // An accepted beat is always followed by the decision step.
  a_accept_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_DECIDE))
    else $error("accepted beat not followed by decision");

  // A new result is only presented after the result state.
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result presented outside result state");
`endif

endmodule

`default_nettype wire

[src/awt_dpath.sv]
// Datapath of the address window translator: configuration registers,
// window table memory, scan compare pipeline, result and output registers.
// Depends on awt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module awt_dpath #(
  parameter int unsigned WINDOWS = awt_pkg::WindowsDefault,
  localparam int unsigned CW = $clog2(WINDOWS + 1),
  localparam int unsigned AW = (WINDOWS > 1) ? $clog2(WINDOWS) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [awt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [awt_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic [awt_pkg::OpW-1:0]       operation_i,
  input  wire logic [awt_pkg::SlotW-1:0]     window_index_i,
  input  wire logic [awt_pkg::AddrW-1:0]     entry_dev_start_i,
  input  wire logic [awt_pkg::AddrW-1:0]     entry_dev_end_i,
  input  wire logic [awt_pkg::AddrW-1:0]     entry_phys_base_i,
  input  wire logic [awt_pkg::AddrW-1:0]     entry_virt_base_i,
  input  wire logic [awt_pkg::AddrW-1:0]     entry_length_i,
  input  wire logic [awt_pkg::AddrW-1:0]     query_addr_i,
  input  wire awt_pkg::ctrl_cmd_t            cmd_i,
  input  wire logic [AW-1:0]                 rd_idx_i,
  output awt_pkg::dp_stat_t                  stat_o,
  output logic [CW-1:0]                      scan_limit_o,
  output logic [awt_pkg::StatusW-1:0]        status_o,
  output logic [awt_pkg::AddrW-1:0]          out_virt_o,
  output logic [awt_pkg::AddrW-1:0]          out_phys_o,
  output logic [awt_pkg::AddrW-1:0]          out_dev_o,
  output logic                               addr_valid_o
);
  import awt_pkg::*;

  // Configuration registers.
  logic [CountW-1:0] win_count_q;
  logic              table_ready_q;
  logic              link_ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_count_q   <= '0;
      table_ready_q <= 1'b0;
      link_ready_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WINDOW_COUNT: win_count_q   <= cfg_data_i;
        CFG_TABLE_READY:  table_ready_q <= cfg_data_i[0];
        CFG_LINK_READY:   link_ready_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The scan never covers more windows than the table holds.
  always_comb begin
    if (int'(win_count_q) > int'(WINDOWS)) scan_limit_o = CW'(WINDOWS);
    else scan_limit_o = CW'(win_count_q);
  end

  // Captured input beat.
  op_e              op_q;
  logic [SlotW-1:0] slot_q;
  entry_t           entry_q;
  logic [AddrW-1:0] query_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q              <= op_e'(operation_i);
      slot_q            <= window_index_i;
      entry_q.dev_start <= entry_dev_start_i;
      entry_q.dev_end   <= entry_dev_end_i;
      entry_q.phys_base <= entry_phys_base_i;
      entry_q.virt_base <= entry_virt_base_i;
      entry_q.length    <= entry_length_i;
      query_q           <= query_addr_i;
    end
  end

  // Early status: the link and table checks come before any scan.
  status_e pre_status;

  always_comb begin
    case (op_q)
      OP_WRITE: pre_status = STATUS_OK;
      OP_DEV2HOST: begin
        if (!link_ready_q) pre_status = STATUS_LINK;
        else if (!table_ready_q) pre_status = STATUS_TABLE;
        else pre_status = STATUS_MISS;
      end
      OP_VIRT2DEV, OP_PHYS2DEV, OP_VALID_TEST: begin
        if (!table_ready_q) pre_status = STATUS_TABLE;
        else pre_status = STATUS_MISS;
      end
      default: pre_status = STATUS_OK;
    endcase
  end

  // Window table: one write port, one registered read port.
  // A per-window use bit makes unwritten windows read as unused.
  entry_t          mem_q [WINDOWS];
  logic [WINDOWS-1:0] used_q;
  logic            wr_ok;
  logic [AW-1:0]   wr_addr;
  entry_t          rd_q;
  logic            rd_used_q;

  assign wr_ok   = int'(slot_q) < int'(WINDOWS);
  assign wr_addr = AW'(slot_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && wr_ok) mem_q[wr_addr] <= entry_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (cmd_i.wr_en && wr_ok) begin
      used_q[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_q      <= mem_q[rd_idx_i];
      rd_used_q <= used_q[rd_idx_i];
    end
  end

  // Pipeline occupancy flags.
  logic v1_q, v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.rd_en;
      v2_q <= v1_q;
    end
  end

  // First compare stage: offset, lower bound, device-side upper bound and host-side window limit.
  logic [AddrW-1:0] host_base, lo_base;
  logic [AddrW-1:0] s2_off_q, s2_sum_q, s2_virt_q, s2_phys_q, s2_start_q;
  logic             s2_ge_lo_q, s2_le_end_q, s2_use_q;

  assign host_base = (op_q == OP_PHYS2DEV) ? rd_q.phys_base : rd_q.virt_base;
  assign lo_base   = (op_q == OP_DEV2HOST) ? rd_q.dev_start : host_base;

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      s2_off_q    <= query_q - lo_base;
      s2_sum_q    <= host_base + rd_q.length;
      s2_ge_lo_q  <= query_q >= lo_base;
      s2_le_end_q <= query_q <= rd_q.dev_end;
      s2_use_q    <= rd_used_q && (rd_q.virt_base != '0);
      s2_virt_q   <= rd_q.virt_base;
      s2_phys_q   <= rd_q.phys_base;
      s2_start_q  <= rd_q.dev_start;
    end
  end

  // Second compare stage: upper bound and hit decision. The inclusive
  // host-side range covers everything above base when base plus length wraps
  // to exactly zero; the valid test uses the plain exclusive limit.
  logic lt_sum, hit;

  assign lt_sum = query_q < s2_sum_q;

  always_comb begin
    case (op_q)
      OP_DEV2HOST:              hit = s2_ge_lo_q && s2_le_end_q;
      OP_VIRT2DEV, OP_PHYS2DEV: hit = s2_ge_lo_q && ((s2_sum_q == '0) || lt_sum);
      OP_VALID_TEST:            hit = s2_ge_lo_q && lt_sum;
      default:                  hit = 1'b0;
    endcase
  end

  // Result registers; the first hit in index order wins.
  status_e          res_status_q;
  logic [AddrW-1:0] res_virt_q, res_phys_q, res_dev_q;
  logic             res_valid_q;
  logic             found_q;
  logic             take_hit;

  assign take_hit = v2_q && s2_use_q && hit && !found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.init) begin
      found_q <= 1'b0;
    end else if (take_hit) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      res_status_q <= pre_status;
      res_virt_q   <= '0;
      res_phys_q   <= '0;
      res_dev_q    <= '0;
      res_valid_q  <= 1'b0;
    end else if (take_hit) begin
      res_status_q <= STATUS_OK;
      case (op_q)
        OP_DEV2HOST: begin
          res_virt_q <= s2_virt_q + s2_off_q;
          res_phys_q <= s2_phys_q + s2_off_q;
        end
        OP_VIRT2DEV, OP_PHYS2DEV: begin
          res_dev_q <= s2_start_q + s2_off_q;
        end
        OP_VALID_TEST: begin
          res_valid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Output beat registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o     <= res_status_q;
      out_virt_o   <= res_virt_q;
      out_phys_o   <= res_phys_q;
      out_dev_o    <= res_dev_q;
      addr_valid_o <= res_valid_q;
    end
  end

  // Status toward the controller.
  assign stat_o.is_write  = (op_q == OP_WRITE);
  assign stat_o.scan_req  = (pre_status == STATUS_MISS);
  assign stat_o.pipe_busy = v1_q || v2_q;

`ifndef SYNTH
  // A recorded hit always carries the success status.
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (res_status_q == STATUS_OK))
    else $error("hit recorded without success status");

  // The compare stage only holds data that came out of the table read.
  a_pipe_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> $past(v1_q))
    else $error("compare stage valid without read stage");

  // The read stage is only filled by a table read command.
  a_read_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> $past(cmd_i.rd_en))
    else $error("read stage valid without read command");
`endif

endmodule

`default_nettype wire
